[rtl/kslr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the key lookup table for the keypad line editor.
// No dependencies; imported by every module of the block.
package kslr_pkg;

   localparam int LINE_SIZE = 16;
   localparam int IDX_W     = (LINE_SIZE > 1) ? $clog2(LINE_SIZE) : 1;
   localparam int LEN_W     = 5;
   localparam int ROWS      = 4;
   localparam int COLS      = 4;

   localparam logic [7:0] ENTER_RESET = 8'd35;

   // Result kinds on the response channel
   localparam logic [1:0] KIND_ECHO  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef enum logic [1:0] {
      CMD_APPEND,
      CMD_ENTER,
      CMD_FLUSH
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] key;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [7:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
      logic [7:0] code;
      unique case ({row, col})
         4'h0: code = "1";
         4'h1: code = "2";
         4'h2: code = "3";
         4'h3: code = "A";
         4'h4: code = "4";
         4'h5: code = "5";
         4'h6: code = "6";
         4'h7: code = "B";
         4'h8: code = "7";
         4'h9: code = "8";
         4'hA: code = "9";
         4'hB: code = "C";
         4'hC: code = "*";
         4'hD: code = "0";
         4'hE: code = 8'd35;
         default: code = "D";
      endcase
      return code;
   endfunction

endpackage

[rtl/kslr_front.sv]
`timescale 1ns / 1ps
// Front end: holds the last column samples, detects new presses, decodes a key
// and classifies it into a command. Depends on kslr_pkg.
module kslr_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             func,
   input  logic [3:0]       row0_cols,
   input  logic [3:0]       row1_cols,
   input  logic [3:0]       row2_cols,
   input  logic [3:0]       row3_cols,
   input  logic [7:0]       enter_code,
   output logic             cmd_push,
   output kslr_pkg::cmd_type cmd
);
   import kslr_pkg::*;

   logic [3:0] prev_ff [ROWS];
   logic [3:0] prev_in [ROWS];
   logic [3:0] now_cols [ROWS];
   logic [3:0] fell;
   logic       found;
   logic [7:0] key;
   logic [1:0] col;

   assign now_cols[0] = row0_cols;
   assign now_cols[1] = row1_cols;
   assign now_cols[2] = row2_cols;
   assign now_cols[3] = row3_cols;

   // Later rows override earlier ones
   always_comb begin
      found = 1'b0;
      key   = 8'd0;
      fell  = 4'd0;
      col   = 2'd0;
      for (int r = 0; r < ROWS; r++) begin
         fell = prev_ff[r] & ~now_cols[r];
         unique case (fell)
            4'b0001: col = 2'd0;
            4'b0010: col = 2'd1;
            4'b0100: col = 2'd2;
            4'b1000: col = 2'd3;
            default: col = 2'd0;
         endcase
         if ($onehot(fell)) begin
            found = 1'b1;
            key   = key_lookup(2'(r), col);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         prev_in[r] = (accept && !func) ? now_cols[r] : prev_ff[r];
      end
   end

   always_comb begin
      cmd.key  = key;
      cmd.op   = (key == enter_code) ? CMD_ENTER : CMD_APPEND;
      cmd_push = accept && (func || found);
      if (func) begin
         cmd.op = CMD_FLUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            prev_ff[r] <= 4'hF;
         end
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

[rtl/kslr_fifo.sv]
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the line back end.
// Depends on kslr_pkg for the command type.
module kslr_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  kslr_pkg::cmd_type        push_data,
   input  logic                     pop,
   output kslr_pkg::cmd_type        pop_data,
   output kslr_pkg::fifo_status_type status
);
   import kslr_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign status.full  = (fill_ff == 2'd2);
   assign status.empty = (fill_ff == 2'd0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[rtl/kslr_back.sv]
`timescale 1ns / 1ps
// Back end: line store memory, line count and the result output register.
// Executes append, enter and flush commands. Depends on kslr_pkg.
module kslr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  kslr_pkg::cmd_type         cmd,
   input  kslr_pkg::fifo_status_type fifo_status,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_char_code,
   output logic [kslr_pkg::LEN_W-1:0] rsp_line_length,
   output logic                      rsp_last
);
   import kslr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       char_ff, char_in;
   logic [LEN_W-1:0] olen_ff, olen_in;
   logic             last_ff, last_in;

   logic [7:0]       mem [LINE_SIZE];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             wr_en;
   logic             out_free;
   logic             line_end;

   assign out_free = !valid_ff || rsp_ready;
   assign line_end = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      char_in  = char_ff;
      olen_in  = olen_ff;
      last_in  = last_ff;
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = (count_ff >= LEN_W'(LINE_SIZE)) ? '0 : count_ff[IDX_W-1:0];
      rd_addr  = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!fifo_status.empty && out_free) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  CMD_APPEND: begin
                     // Restart the line when full, then append
                     wr_en    = 1'b1;
                     count_in = LEN_W'(wr_addr) + LEN_W'(1);
                     valid_in = 1'b1;
                     kind_in  = KIND_ECHO;
                     char_in  = cmd.key;
                     olen_in  = LEN_W'(wr_addr) + LEN_W'(1);
                     last_in  = 1'b1;
                  end
                  CMD_ENTER: begin
                     count_in = '0;
                     if (count_ff == '0) begin
                        valid_in = 1'b1;
                        kind_in  = KIND_EMPTY;
                        char_in  = cmd.key;
                        olen_in  = '0;
                        last_in  = 1'b1;
                     end else begin
                        len_in   = count_ff;
                        idx_in   = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               valid_in = 1'b1;
               kind_in  = KIND_LINE;
               char_in  = rd_data_ff;
               olen_in  = len_ff;
               last_in  = line_end;
               if (line_end) begin
                  state_in = ST_IDLE;
               end else begin
                  // Prefetch the next character while this one goes out
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.key;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      kind_ff <= kind_in;
      char_ff <= char_in;
      olen_ff <= olen_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_char_code   = char_ff;
   assign rsp_line_length = olen_ff;
   assign rsp_last        = last_ff;

endmodule

[rtl/keypad_scan_line_editor_unit.sv]
`timescale 1ns / 1ps
// Keypad scanner with line editor, top level: front end, command queue and
// back end. Depends on kslr_pkg, kslr_front, kslr_fifo and kslr_back.
//
// Usage:
//  - req channel (valid/ready): one scan transaction carries four active-low
//    4-bit column samples, or a flush (req_func = 1) that empties the line.
//  - rsp channel (valid/ready): key echoes, line characters (one per
//    transaction, rsp_last on the final one) and empty-line markers.
//  - csr port: csr_wr_en writes csr_wr_data into the enter key code; write
//    only while the block is idle.
// Timing:
//  - A scan is taken when the two-entry command queue has room; scans
//    without a new key produce nothing and never occupy the queue.
//  - An echo passes through the command queue and is then popped into the
//    output register once that is free. Enter of an n-character line emits n
//    transactions back to back while rsp_ready holds: pop, a line store read
//    in ST_FETCH, then one character per cycle in ST_EMIT, set by the single
//    read port of the line store.
// Reset: all columns read as released, the line is empty, enter code is '#'.
// Stall: a held rsp freezes the back end; the front keeps taking scans until
// the queue fills, then drops req_ready.
module keypad_scan_line_editor_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_func,
   input  logic [3:0] req_row0_cols,
   input  logic [3:0] req_row1_cols,
   input  logic [3:0] req_row2_cols,
   input  logic [3:0] req_row3_cols,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_char_code,
   output logic [4:0] rsp_line_length,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import kslr_pkg::*;

   logic [7:0]      enter_ff, enter_in;
   logic            req_accept;
   logic            cmd_push, cmd_pop;
   cmd_type         push_cmd, pop_cmd;
   fifo_status_type fifo_status;

   // Hold the enter key code; it is to be written only while idle (not enforced here)
   assign enter_in = csr_wr_en ? csr_wr_data : enter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_ff <= ENTER_RESET;
      end else begin
         enter_ff <= enter_in;
      end
   end

   // Take a scan whenever the queue can absorb the command it may produce
   assign req_ready  = !fifo_status.full;
   assign req_accept = req_valid && req_ready;

   kslr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .func       (req_func),
      .row0_cols  (req_row0_cols),
      .row1_cols  (req_row1_cols),
      .row2_cols  (req_row2_cols),
      .row3_cols  (req_row3_cols),
      .enter_code (enter_ff),
      .cmd_push   (cmd_push),
      .cmd        (push_cmd)
   );

   kslr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .status    (fifo_status)
   );

   kslr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd             (pop_cmd),
      .fifo_status     (fifo_status),
      .cmd_pop         (cmd_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_code   (rsp_char_code),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last)
   );

   // An empty-line marker or an echo always closes its transaction run
   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EMPTY || rsp_kind == KIND_ECHO) |-> rsp_last)
      else $error("single result without last");

   // An echo reports a nonzero length within the line size
   a_echo_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_ECHO |->
         rsp_line_length != 5'd0 && rsp_line_length <= 5'(LINE_SIZE))
      else $error("echo length out of range");

   // Never push into a full queue: the front would lose a command
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !fifo_status.full)
      else $error("command queue overflow");

   // Only pop commands that exist
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fifo_status.empty)
      else $error("command queue underflow");

endmodule

[sim/kslr_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the keypad line editor. It watches the req, rsp and csr ports,
// predicts the results of each scan transaction and compares them in order.
// Depends on kslr_pkg.
module kslr_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic       req_func,
   input  logic [3:0] req_row0_cols,
   input  logic [3:0] req_row1_cols,
   input  logic [3:0] req_row2_cols,
   input  logic [3:0] req_row3_cols,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_char_code,
   input  logic [4:0] rsp_line_length,
   input  logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   output int         fail_count,
   output int         pending
);
   import kslr_pkg::*;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [4:0] line_length;
      logic       last;
   } editor_result_type;

   // Keypad legend, byte 0 is row 0 column 0, byte 15 is row 3 column 3
   localparam logic [15:0][7:0] KEY_LEGEND = "D#0*C987B654A321";

   logic [3:0][3:0]   held_cols;
   logic [7:0]        line_chars [LINE_SIZE];
   int                line_fill;
   logic [7:0]        enter_key;
   editor_result_type due_results [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [7:0] ch,
                              input int len, input logic last);
      editor_result_type res;
      res.kind        = kind;
      res.char_code   = ch;
      res.line_length = 5'(len);
      res.last        = last;
      due_results.push_back(res);
   endtask

   // Work out the results of one accepted scan or flush transaction
   task automatic predict_scan(input logic func, input logic [3:0][3:0] cols);
      logic [3:0] fell;
      logic [7:0] key;
      logic       hit;
      int         r, c, n, i;
      if (func) begin
         line_fill = 0;
         return;
      end
      hit = 1'b0;
      key = 8'd0;
      for (r = 0; r < ROWS; r++) begin
         fell         = held_cols[r] & ~cols[r];
         held_cols[r] = cols[r];
         for (c = 0; c < COLS; c++) begin
            if (fell == (4'b0001 << c)) begin
               key = KEY_LEGEND[r * COLS + c];
               hit = 1'b1;
            end
         end
      end
      if (!hit) begin
         return;
      end
      if (key == enter_key) begin
         n         = line_fill;
         line_fill = 0;
         if (n == 0) begin
            push_result(KIND_EMPTY, key, 0, 1'b1);
         end else begin
            for (i = 0; i < n; i++) begin
               push_result(KIND_LINE, line_chars[i], n, i == n - 1);
            end
         end
      end else begin
         if (line_fill >= LINE_SIZE) begin
            line_fill = 0;
         end
         line_chars[line_fill] = key;
         line_fill++;
         push_result(KIND_ECHO, key, line_fill, 1'b1);
      end
   endtask

   always @(posedge clock) begin : watch
      editor_result_type want;
      if (reset) begin
         held_cols = '1;
         line_fill = 0;
         enter_key = ENTER_RESET;
         due_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_scan(req_func,
                         {req_row3_cols, req_row2_cols, req_row1_cols, req_row0_cols});
         end
         if (csr_wr_en) begin
            enter_key = csr_wr_data;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result kind %0d char %0d len %0d last %0d",
                                         rsp_kind, rsp_char_code, rsp_line_length, rsp_last));
            end else begin
               want = due_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_char_code !== want.char_code)
                  report_mismatch($sformatf("char_code %0d, want %0d",
                                            rsp_char_code, want.char_code));
               if (rsp_line_length !== want.line_length)
                  report_mismatch($sformatf("line_length %0d, want %0d",
                                            rsp_line_length, want.line_length));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0d, want %0d", rsp_last, want.last));
            end
         end
      end
      pending = due_results.size();
   end

endmodule

[sim/keypad_scan_line_editor_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the keypad line editor: clock, reset, scan stimulus,
// enter-code settings and the verdict. Depends on kslr_pkg,
// keypad_scan_line_editor_unit and kslr_checker.
module keypad_scan_line_editor_unit_tb;
   import kslr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 30;
   // Enter codes to run through, in order: two outside the keypad legend
   localparam logic [0:7][7:0] ENTER_PLAN = {8'd35, "A", 8'd0, "1", "D", 8'd255, "5", 8'd35};

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_func;
   logic [3:0] req_row0_cols;
   logic [3:0] req_row1_cols;
   logic [3:0] req_row2_cols;
   logic [3:0] req_row3_cols;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_code;
   logic [4:0] rsp_line_length;
   logic       rsp_last;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   // Legend position of the current enter key, -1 when it is not on the keypad
   int enter_pos   = 14;
   // Column samples last driven per row; lets the stimulus aim at one key
   logic [3:0] sent_cols [4];

   int rx_mode      = 0;
   int rx_mode_left = 0;
   int rx_hold      = 0;

   always #5 clock = ~clock;

   keypad_scan_line_editor_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_row0_cols   (req_row0_cols),
      .req_row1_cols   (req_row1_cols),
      .req_row2_cols   (req_row2_cols),
      .req_row3_cols   (req_row3_cols),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_code   (rsp_char_code),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   kslr_checker line_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_row0_cols   (req_row0_cols),
      .req_row1_cols   (req_row1_cols),
      .req_row2_cols   (req_row2_cols),
      .req_row3_cols   (req_row3_cols),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_char_code   (rsp_char_code),
      .rsp_line_length (rsp_line_length),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: switch between randomly chosen stall styles so that
   // back-pressure lands on every beat of a line burst. Mode 0 never stalls.
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      = $urandom_range(0, 3);
         rx_mode_left = $urandom_range(20, 150);
      end else begin
         rx_mode_left--;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            // long runs of stall and flow, of random length
            if (rx_hold == 0) begin
               rx_hold = $urandom_range(1, 12);
               rsp_ready <= ~rsp_ready;
            end else begin
               rx_hold--;
            end
         end
      endcase
   end

   // Present one transaction and hold it until accepted. Called and returns
   // at a falling edge; valid stays high on return so a burst runs back to back.
   task automatic send_scan(input logic func, input logic [3:0] r0, input logic [3:0] r1,
                            input logic [3:0] r2, input logic [3:0] r3);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_func      <= func;
      req_row0_cols <= r0;
      req_row1_cols <= r1;
      req_row2_cols <= r2;
      req_row3_cols <= r3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      // a flush leaves the stored samples alone
      if (!func) begin
         sent_cols[0] = r0;
         sent_cols[1] = r1;
         sent_cols[2] = r2;
         sent_cols[3] = r3;
      end
      items_sent++;
   endtask

   // Drop valid and hold off until every predicted result has been taken
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Press the key at legend position pos: exactly one column of its row goes
   // from released to pressed, and other rows only release random columns.
   task automatic tap_key(input int pos);
      logic [3:0] cols [4];
      int         row, i;
      row = pos / COLS;
      if (sent_cols[row][pos % COLS] == 1'b0) begin
         // still held from before: release the row first
         for (i = 0; i < ROWS; i++) cols[i] = sent_cols[i] | 4'($urandom_range(0, 15));
         cols[row] = 4'hF;
         send_scan(1'b0, cols[0], cols[1], cols[2], cols[3]);
      end
      for (i = 0; i < ROWS; i++) cols[i] = sent_cols[i] | 4'($urandom_range(0, 15));
      cols[row] = cols[row] & ~(4'b0001 << (pos % COLS));
      send_scan(1'b0, cols[0], cols[1], cols[2], cols[3]);
   endtask

   function automatic int pick_plain_key();
      int pos;
      do pos = $urandom_range(0, 15); while (pos == enter_pos);
      return pos;
   endfunction

   // Type one line of random keys and end it with enter. Lengths favor the
   // empty line, a full buffer and overflow; stray scans and flushes break
   // some lines on the way.
   task automatic type_line();
      int goal, k, roll;
      roll = $urandom_range(0, 9);
      if (roll < 2) goal = LINE_SIZE;
      else if (roll == 2) goal = 0;
      else if (roll == 3) goal = $urandom_range(LINE_SIZE + 1, LINE_SIZE + 4);
      else goal = $urandom_range(1, LINE_SIZE - 1);
      for (k = 0; k < goal; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            send_scan(1'b0, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end else if (roll < 9) begin
            send_scan(1'b1, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                      4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         end
         tap_key(pick_plain_key());
      end
      if ($urandom_range(0, 7) == 0) begin
         wait_results_drained();
      end
      // with enter off the keypad this is just one more key
      tap_key((enter_pos >= 0) ? enter_pos : pick_plain_key());
   endtask

   // Change the enter code with the block idle: drain, let any flushes
   // still queued inside work through, then write for one cycle.
   task automatic set_enter(input logic [7:0] code);
      int pos;
      wait_results_drained();
      repeat (10) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      enter_pos = -1;
      for (pos = 0; pos < ROWS * COLS; pos++) begin
         if (key_lookup(2'(pos / COLS), 2'(pos % COLS)) == code) enter_pos = pos;
      end
   endtask

   initial begin
      int phase, start;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = 1'b0;
      req_row0_cols = 4'hF;
      req_row1_cols = 4'hF;
      req_row2_cols = 4'hF;
      req_row3_cols = 4'hF;
      rsp_ready     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 8'd0;
      for (int i = 0; i < ROWS; i++) sent_cols[i] = 4'hF;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk with the reset enter code '#'
      send_scan(1'b1, 4'h0, 4'h0, 4'h0, 4'h0);   // flush, rows ignored
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hB);   // enter on an empty line
      send_scan(1'b0, 4'hE, 4'hF, 4'hF, 4'hF);   // '1', row 3 released
      send_scan(1'b0, 4'hD, 4'hF, 4'hF, 4'hF);   // '2': slide to the next column
      send_scan(1'b0, 4'hB, 4'hF, 4'hF, 4'hF);   // '3'
      send_scan(1'b0, 4'h7, 4'hF, 4'hF, 4'hF);   // 'A'
      send_scan(1'b0, 4'h7, 4'hE, 4'hE, 4'hF);   // rows 1 and 2 both: row 2 wins
      send_scan(1'b0, 4'h7, 4'hE, 4'h8, 4'hF);   // two columns fall in row 2: no key
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hF);   // release all
      send_scan(1'b0, 4'h0, 4'h0, 4'h0, 4'h0);   // every column falls: no key
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hF);
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hE);   // '*'
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hD);   // '0'
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'h7);   // 'D'
      send_scan(1'b0, 4'hF, 4'h7, 4'hF, 4'hF);   // 'B'
      send_scan(1'b0, 4'hF, 4'hF, 4'hB, 4'hB);   // '9' and enter: enter wins, line out
      send_scan(1'b0, 4'hF, 4'hE, 4'hF, 4'hF);   // '4'
      send_scan(1'b1, 4'h0, 4'h0, 4'h0, 4'h0);   // flush keeps row samples
      send_scan(1'b0, 4'hF, 4'hE, 4'hF, 4'hB);   // enter after flush: empty line
      send_scan(1'b0, 4'hF, 4'hF, 4'hF, 4'hF);

      // Random lines under each enter code, including both code extremes
      for (phase = 0; phase < 8; phase++) begin
         set_enter(ENTER_PLAN[phase]);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) type_line();
      end

      // Drain, then give the block time to surface anything stray
      wait_results_drained();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
